/* rtl/core/lexical_token_classifier_assert.svh */
// assertion macros for the rtl files (used by lexical_token_classifier.sv)
`ifndef LEXICAL_TOKEN_CLASSIFIER_ASSERT_SVH
`define LEXICAL_TOKEN_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ltc assertion failed");

// next-cycle implication, checked outside reset
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ltc assertion failed");

`endif

/* rtl/core/ltc_pkg.sv */
package ltc_pkg;

  localparam int LengthLimit = 255;
  // length counter saturates at the limit, never beyond 8 bits
  localparam logic [7:0] LEN_CAP = 8'((LengthLimit > 255) ? 255 : LengthLimit);

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_UNDER  = 8'd95;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_AMP    = 8'd38;
  localparam logic [7:0] CH_BAR    = 8'd124;
  localparam logic [7:0] CH_BANG   = 8'd33;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_LPAR   = 8'd40;
  localparam logic [7:0] CH_RPAR   = 8'd41;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  localparam int KwSlots = 6;
  localparam logic [7:0] KW_SLOTS = 8'(KwSlots);

  typedef logic [4:0] tok_class_t;
  localparam tok_class_t CLS_IDENT    = 5'd0;
  localparam tok_class_t CLS_INT      = 5'd1;
  localparam tok_class_t CLS_REAL     = 5'd2;
  localparam tok_class_t CLS_TYPE     = 5'd3;
  localparam tok_class_t CLS_ADD      = 5'd4;
  localparam tok_class_t CLS_MUL      = 5'd5;
  localparam tok_class_t CLS_RELOP    = 5'd6;
  localparam tok_class_t CLS_OR       = 5'd7;
  localparam tok_class_t CLS_AND      = 5'd8;
  localparam tok_class_t CLS_NOT      = 5'd9;
  localparam tok_class_t CLS_EQUALITY = 5'd10;
  localparam tok_class_t CLS_SEMI     = 5'd11;
  localparam tok_class_t CLS_COMMA    = 5'd12;
  localparam tok_class_t CLS_LPAR     = 5'd13;
  localparam tok_class_t CLS_RPAR     = 5'd14;
  localparam tok_class_t CLS_LBRACE   = 5'd15;
  localparam tok_class_t CLS_RBRACE   = 5'd16;
  localparam tok_class_t CLS_ASSIGN   = 5'd17;
  localparam tok_class_t CLS_IF       = 5'd18;
  localparam tok_class_t CLS_WHILE    = 5'd19;
  localparam tok_class_t CLS_RETURN   = 5'd20;
  localparam tok_class_t CLS_ELSE     = 5'd21;
  localparam tok_class_t CLS_INVALID  = 5'd22;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_INT   = 4'd1,
    ST_IDENT = 4'd2,
    ST_DOT   = 4'd3,
    ST_FRAC  = 4'd4,
    ST_DONE  = 4'd5,
    ST_EQ    = 4'd6,
    ST_REL   = 4'd7,
    ST_AMP   = 4'd8,
    ST_BAR   = 4'd9,
    ST_BANG  = 4'd10,
    ST_ERR   = 4'd11
  } scan_state_e;

  typedef logic [KwSlots-1:0][7:0] kw_chars_t;

  // next-state bundle from the step logic to the scanner registers
  typedef struct packed {
    scan_state_e state;
    tok_class_t  pending;
    logic [7:0]  count;
    logic        ovf;
    logic        kw_we;
    logic [2:0]  kw_idx;
    logic        emit;
    tok_class_t  tok_class;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  // keyword lookup on the stored prefix; length must match exactly
  function automatic tok_class_t kw_class(input kw_chars_t ch, input logic [7:0] n);
    tok_class_t cls;
    cls = CLS_IDENT;
    case (n)
      8'd2: if ({ch[0], ch[1]} == "if") cls = CLS_IF;
      8'd3: if ({ch[0], ch[1], ch[2]} == "int") cls = CLS_TYPE;
      8'd4: if ({ch[0], ch[1], ch[2], ch[3]} == "else") cls = CLS_ELSE;
      8'd5: begin
        if ({ch[0], ch[1], ch[2], ch[3], ch[4]} == "float") cls = CLS_TYPE;
        else if ({ch[0], ch[1], ch[2], ch[3], ch[4]} == "while") cls = CLS_WHILE;
      end
      8'd6: if ({ch[0], ch[1], ch[2], ch[3], ch[4], ch[5]} == "return") cls = CLS_RETURN;
      default: cls = CLS_IDENT;
    endcase
    return cls;
  endfunction

endpackage

/* rtl/core/ltc_intf.sv */
interface ltc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface ltc_token_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_class;
  logic [7:0] lexeme_length;
  logic       length_saturated;

  modport source (output valid, output token_class, output lexeme_length,
                  output length_saturated, input ready);
  modport sink (input valid, input token_class, input lexeme_length,
                input length_saturated, output ready);
endinterface

/* rtl/core/lexical_token_classifier.sv */
// channel   | dir | payload                                      | beat
// ----------+-----+----------------------------------------------+---------------------------
// char_i    | in  | char_code[7:0]                               | one character
// token_o   | out | token_class[4:0] lexeme_length[7:0] length_saturated | one closed lexeme
//
// one character per cycle sustained unless a space waits on a stalled token_o; a closing
// space goes through the input register, then the scanner step loads the token register
// the scanner step is a single state transition plus a six-byte keyword compare
// reset clears the scanner state, the length counter and both valid flags
// a stalled token_o blocks only a space waiting in the input register; other
// characters keep flowing while a token waits to be taken
`include "lexical_token_classifier_assert.svh"

module lexical_token_classifier
  import ltc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ltc_char_if.sink    char_i,
  ltc_token_if.source token_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_space;
  logic       in_adv;

  // scanner registers
  scan_state_e state_q;
  tok_class_t  pend_q;
  logic [7:0]  count_q;
  logic        ovf_q;
  kw_chars_t   kw_q;   // first characters of the current identifier, no reset needed

  // token register
  logic       out_valid_q;
  tok_class_t out_class_q;
  logic [7:0] out_len_q;
  logic       out_sat_q;
  logic       out_free;

  step_t step;

  assign in_space = (in_char_q == CH_SPACE);
  assign out_free = !out_valid_q || token_o.ready;
  // a space needs room in the token register, anything else always advances
  assign in_adv   = in_valid_q && (!in_space || out_free);
  assign char_i.ready = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
    end
  end

  ltc_step u_step (
    .state_i   (state_q),
    .pending_i (pend_q),
    .count_i   (count_q),
    .ovf_i     (ovf_q),
    .kw_i      (kw_q),
    .char_i    (in_char_q),
    .step_o    (step)
  );

  // scanner state advances once per character leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= CLS_IDENT;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_adv) begin
      state_q <= step.state;
      pend_q  <= step.pending;
      count_q <= step.count;
      ovf_q   <= step.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && step.kw_we) begin
      kw_q[step.kw_idx] <= in_char_q;
    end
  end

  // token register: loaded by a closing space, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_adv && step.emit) begin
      out_valid_q <= 1'b1;
    end else if (token_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && step.emit) begin
      out_class_q <= step.tok_class;
      out_len_q   <= count_q;
      out_sat_q   <= ovf_q;
    end
  end

  assign token_o.valid            = out_valid_q;
  assign token_o.token_class      = out_class_q;
  assign token_o.lexeme_length    = out_len_q;
  assign token_o.length_saturated = out_sat_q;

  // class codes stay inside the defined range
  `LTC_ASSERT_IMP(a_class_range, out_valid_q, out_class_q <= CLS_INVALID)
  // a saturated lexeme always reports the capped length
  `LTC_ASSERT_IMP(a_sat_len, out_valid_q && out_sat_q, out_len_q == LEN_CAP)
  // a saturated lexeme is never a keyword
  `LTC_ASSERT_IMP(a_sat_no_kw, out_valid_q && out_sat_q,
    out_class_q != CLS_TYPE && out_class_q != CLS_IF && out_class_q != CLS_WHILE &&
    out_class_q != CLS_RETURN && out_class_q != CLS_ELSE)
  // a closing space returns the scanner to the start with a clear count
  `LTC_ASSERT_NEXT(a_space_clears, in_adv && in_space,
    state_q == ST_IDLE && count_q == 8'd0 && !ovf_q && out_valid_q)
  // a held character is not dropped while the token register is full
  `LTC_ASSERT_NEXT(a_hold_char, in_valid_q && !in_adv, in_valid_q && $stable(in_char_q))

endmodule

/* rtl/core/ltc_step.sv */
module ltc_step
  import ltc_pkg::*;
(
  input  scan_state_e state_i,
  input  tok_class_t  pending_i,
  input  logic [7:0]  count_i,
  input  logic        ovf_i,
  input  kw_chars_t   kw_i,
  input  logic [7:0]  char_i,
  output step_t       step_o
);

  logic       dig;
  logic       let_c;
  scan_state_e nst;
  tok_class_t npend;
  tok_class_t close_cls;

  assign dig   = is_digit(char_i);
  assign let_c = is_letter(char_i);

  // class reported when a space closes the lexeme
  always_comb begin
    case (state_i)
      ST_INT:   close_cls = CLS_INT;
      ST_IDENT: close_cls = ovf_i ? CLS_IDENT : kw_class(kw_i, count_i);
      ST_FRAC:  close_cls = CLS_REAL;
      ST_DONE:  close_cls = pending_i;
      ST_EQ:    close_cls = CLS_ASSIGN;
      ST_REL:   close_cls = CLS_RELOP;
      ST_BANG:  close_cls = CLS_NOT;
      default:  close_cls = CLS_INVALID;
    endcase
  end

  // scanner transition on a non-space character
  always_comb begin
    nst   = ST_ERR;
    npend = pending_i;
    case (state_i)
      ST_IDLE: begin
        if (dig) nst = ST_INT;
        else if (let_c) nst = ST_IDENT;
        else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
          nst = ST_DONE; npend = CLS_ADD;
        end else if (char_i == CH_STAR || char_i == CH_SLASH) begin
          nst = ST_DONE; npend = CLS_MUL;
        end else if (char_i == CH_EQ) nst = ST_EQ;
        else if (char_i == CH_LT || char_i == CH_GT) nst = ST_REL;
        else if (char_i == CH_AMP) nst = ST_AMP;
        else if (char_i == CH_BAR) nst = ST_BAR;
        else if (char_i == CH_BANG) nst = ST_BANG;
        else if (char_i == CH_SEMI) begin
          nst = ST_DONE; npend = CLS_SEMI;
        end else if (char_i == CH_COMMA) begin
          nst = ST_DONE; npend = CLS_COMMA;
        end else if (char_i == CH_LPAR) begin
          nst = ST_DONE; npend = CLS_LPAR;
        end else if (char_i == CH_RPAR) begin
          nst = ST_DONE; npend = CLS_RPAR;
        end else if (char_i == CH_LBRACE) begin
          nst = ST_DONE; npend = CLS_LBRACE;
        end else if (char_i == CH_RBRACE) begin
          nst = ST_DONE; npend = CLS_RBRACE;
        end else nst = ST_ERR;
      end
      ST_INT: begin
        if (dig) nst = ST_INT;
        else if (char_i == CH_DOT) nst = ST_DOT;
        else nst = ST_ERR;
      end
      ST_IDENT: nst = (dig || let_c || char_i == CH_UNDER) ? ST_IDENT : ST_ERR;
      ST_DOT, ST_FRAC: nst = dig ? ST_FRAC : ST_ERR;
      ST_EQ, ST_BANG: begin
        if (char_i == CH_EQ) begin
          nst = ST_DONE; npend = CLS_EQUALITY;
        end
      end
      ST_REL: begin
        if (char_i == CH_EQ) begin
          nst = ST_DONE; npend = CLS_RELOP;
        end
      end
      ST_AMP: begin
        if (char_i == CH_AMP) begin
          nst = ST_DONE; npend = CLS_AND;
        end
      end
      ST_BAR: begin
        if (char_i == CH_BAR) begin
          nst = ST_DONE; npend = CLS_OR;
        end
      end
      default: nst = ST_ERR;
    endcase
  end

  always_comb begin
    step_o = '0;
    step_o.tok_class = close_cls;
    step_o.kw_idx    = count_i[2:0];
    if (char_i == CH_SPACE) begin
      step_o.emit    = 1'b1;
      step_o.state   = ST_IDLE;
      step_o.pending = CLS_IDENT;
      step_o.count   = '0;
      step_o.ovf     = 1'b0;
    end else begin
      step_o.state   = nst;
      step_o.pending = npend;
      step_o.kw_we   = (nst == ST_IDENT) && (count_i < KW_SLOTS);
      if (count_i < LEN_CAP) begin
        step_o.count = count_i + 8'd1;
        step_o.ovf   = ovf_i;
      end else begin
        step_o.count = count_i;
        step_o.ovf   = 1'b1;
      end
    end
  end

endmodule
